[rtl/csi_pkg.sv]
// Shared widths, types and helpers for the complex symmetric 3x3 inverse pipeline.
`default_nettype none
package csi_pkg;

	localparam int P = 32;
	localparam int F = 16;
	localparam int WX = 3 * P + 4;
	localparam int WP = 2 * WX;
	localparam int LIMBS = 4;
	localparam int LW = (WX + LIMBS - 1) / LIMBS;
	localparam int WL = LIMBS * LW;
	localparam int WQ = 2 * WL;
	localparam int WC = WP + P + 2 * F;
	localparam int LM = 4;
	localparam int LC = LM + 1;
	localparam int LD = P + 2;
	localparam int LAT = 3 * LC + LD + 2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SING,
		ST_SAT
	} status_t;

	typedef struct packed {
		logic signed [WX-1:0] re;
		logic signed [WX-1:0] im;
	} cx_t;

	typedef struct packed {
		logic signed [WP-1:0] re;
		logic signed [WP-1:0] im;
	} cp_t;

	function automatic cx_t cx_in(input logic [63:0] v);
		cx_t r;
		r.re = WX'($signed(v[2*P-1:P]));
		r.im = WX'($signed(v[P-1:0]));
		return r;
	endfunction

	function automatic cx_t cx_tr(input cp_t p);
		cx_t r;
		r.re = p.re[WX-1:0];
		r.im = p.im[WX-1:0];
		return r;
	endfunction

	// part-wise difference of two wide products, cut to operand width
	function automatic cx_t cp_diff(input cp_t x, input cp_t y);
		cx_t r;
		r.re = WX'(x.re - y.re);
		r.im = WX'(x.im - y.im);
		return r;
	endfunction

	function automatic cx_t cx_conj(input cx_t c);
		cx_t r;
		r.re = c.re;
		r.im = -$signed(c.im);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/complex_symmetric_3x3_inverse.sv]
// Top level: complex symmetric 3x3 inverse as adjugate over determinant.
//  channel | signals                                   | role
//  in      | in_valid, in_ready, alpha_*, last_in      | one matrix per transfer
//  out     | out_valid, out_ready, inv_*, status, last_out | six inverse entries
// One transfer per cycle while the output is not stalled; the path runs through three complex
// multiply levels, a bit-per-stage divider, the determinant register and the output registers.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears only the valid, last and singular markers; data registers are not reset.
`default_nettype none
module complex_symmetric_3x3_inverse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] alpha_d1,
	input  wire logic [63:0] alpha_d2,
	input  wire logic [63:0] alpha_d3,
	input  wire logic [63:0] alpha_o1,
	input  wire logic [63:0] alpha_o2,
	input  wire logic [63:0] alpha_o3,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      inv_d1,
	output logic [63:0]      inv_d2,
	output logic [63:0]      inv_d3,
	output logic [63:0]      inv_o1,
	output logic [63:0]      inv_o2,
	output logic [63:0]      inv_o3,
	output logic [1:0]       status,
	output logic             last_out
);

	localparam int LC = csi_pkg::LC;
	localparam int LD = csi_pkg::LD;
	localparam int LAT = csi_pkg::LAT;
	localparam int P = csi_pkg::P;

	logic en;
	logic vld_q [LAT];
	logic lst_q [LAT];
	logic sgl_q [LC+LD];

	csi_pkg::cx_t a [3];
	csi_pkg::cx_t b [3];
	csi_pkg::cx_t l1a [12];
	csi_pkg::cx_t l1b [12];
	csi_pkg::cp_t l1p [12];
	csi_pkg::cx_t l2a [5];
	csi_pkg::cx_t l2b [5];
	csi_pkg::cp_t l2p [5];
	csi_pkg::cx_t l3a [7];
	csi_pkg::cx_t l3b [7];
	csi_pkg::cp_t l3p [7];
	csi_pkg::cx_t adl_q [LC][4];
	csi_pkg::cx_t n_s6 [6];
	csi_pkg::cx_t ndl_q [LC][6];
	csi_pkg::cx_t det_s11;
	logic [P-1:0] dq [12];
	logic         ds [12];
	logic [63:0]  inv_q [6];
	csi_pkg::status_t status_q;
	logic         any_sat;
	logic         sing;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	assign a[0] = csi_pkg::cx_in(alpha_d1);
	assign a[1] = csi_pkg::cx_in(alpha_d2);
	assign a[2] = csi_pkg::cx_in(alpha_d3);
	assign b[0] = csi_pkg::cx_in(alpha_o1);
	assign b[1] = csi_pkg::cx_in(alpha_o2);
	assign b[2] = csi_pkg::cx_in(alpha_o3);

	// level 1: squares and pair products of the inputs
	assign l1a[0] = b[0];  assign l1b[0] = b[0];
	assign l1a[1] = b[1];  assign l1b[1] = b[1];
	assign l1a[2] = b[2];  assign l1b[2] = b[2];
	assign l1a[3] = b[0];  assign l1b[3] = b[1];
	assign l1a[4] = a[0];  assign l1b[4] = a[1];
	assign l1a[5] = a[1];  assign l1b[5] = a[2];
	assign l1a[6] = a[2];  assign l1b[6] = a[0];
	assign l1a[7] = b[1];  assign l1b[7] = b[2];
	assign l1a[8] = b[2];  assign l1b[8] = b[0];
	assign l1a[9] = a[0];  assign l1b[9] = b[0];
	assign l1a[10] = a[1]; assign l1b[10] = b[1];
	assign l1a[11] = a[2]; assign l1b[11] = b[2];

	// level 2: triple products for the determinant
	assign l2a[0] = csi_pkg::cx_tr(l1p[3]); assign l2b[0] = adl_q[LC-1][3];
	assign l2a[1] = csi_pkg::cx_tr(l1p[4]); assign l2b[1] = adl_q[LC-1][2];
	assign l2a[2] = csi_pkg::cx_tr(l1p[0]); assign l2b[2] = adl_q[LC-1][0];
	assign l2a[3] = csi_pkg::cx_tr(l1p[1]); assign l2b[3] = adl_q[LC-1][1];
	assign l2a[4] = csi_pkg::cx_tr(l1p[2]); assign l2b[4] = adl_q[LC-1][2];

	// level 3: adjugate times conj(det), and |det|^2
	for (genvar k = 0; k < 6; k++) begin : g_l3
		assign l3a[k] = ndl_q[LC-1][k];
		assign l3b[k] = csi_pkg::cx_conj(det_s11);
	end
	assign l3a[6] = det_s11;
	assign l3b[6] = csi_pkg::cx_conj(det_s11);

	for (genvar k = 0; k < 12; k++) begin : g_m1
		csi_cmul u_m (.clk(clk), .en(en), .a(l1a[k]), .b(l1b[k]), .p(l1p[k]));
	end
	for (genvar k = 0; k < 5; k++) begin : g_m2
		csi_cmul u_m (.clk(clk), .en(en), .a(l2a[k]), .b(l2b[k]), .p(l2p[k]));
	end
	for (genvar k = 0; k < 7; k++) begin : g_m3
		csi_cmul u_m (.clk(clk), .en(en), .a(l3a[k]), .b(l3b[k]), .p(l3p[k]));
	end
	for (genvar k = 0; k < 6; k++) begin : g_dv
		csi_div u_re (.clk(clk), .en(en), .num(l3p[k].re), .mag(l3p[6].re),
			.q(dq[2*k]), .sat(ds[2*k]));
		csi_div u_im (.clk(clk), .en(en), .num(l3p[k].im), .mag(l3p[6].re),
			.q(dq[2*k+1]), .sat(ds[2*k+1]));
	end

	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < 12; k++) begin
			any_sat = any_sat | ds[k];
		end
	end

	assign sing = sgl_q[LC+LD-1];

	always_ff @(posedge clk) begin
		if (en) begin
			adl_q[0][0] <= a[0];
			adl_q[0][1] <= a[1];
			adl_q[0][2] <= a[2];
			adl_q[0][3] <= b[2];
			for (int i = 1; i < LC; i++) begin
				adl_q[i] <= adl_q[i-1];
			end
			n_s6[0] <= csi_pkg::cp_diff(l1p[5], l1p[0]);
			n_s6[1] <= csi_pkg::cp_diff(l1p[6], l1p[1]);
			n_s6[2] <= csi_pkg::cp_diff(l1p[4], l1p[2]);
			n_s6[3] <= csi_pkg::cp_diff(l1p[7], l1p[9]);
			n_s6[4] <= csi_pkg::cp_diff(l1p[8], l1p[10]);
			n_s6[5] <= csi_pkg::cp_diff(l1p[3], l1p[11]);
			ndl_q[0] <= n_s6;
			for (int i = 1; i < LC; i++) begin
				ndl_q[i] <= ndl_q[i-1];
			end
			det_s11.re <= csi_pkg::WX'(l2p[1].re + (l2p[0].re <<< 1) - l2p[2].re
				- l2p[3].re - l2p[4].re);
			det_s11.im <= csi_pkg::WX'(l2p[1].im + (l2p[0].im <<< 1) - l2p[2].im
				- l2p[3].im - l2p[4].im);
			for (int k = 0; k < 6; k++) begin
				inv_q[k] <= sing ? 64'd0 : 64'({dq[2*k], dq[2*k+1]});
			end
			status_q <= sing ? csi_pkg::ST_SING : (any_sat ? csi_pkg::ST_SAT : csi_pkg::ST_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
				lst_q[i] <= 1'b0;
			end
			for (int i = 0; i < LC + LD; i++) begin
				sgl_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			lst_q[0] <= last_in;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
				lst_q[i] <= lst_q[i-1];
			end
			sgl_q[0] <= (det_s11.re == '0) && (det_s11.im == '0);
			for (int i = 1; i < LC + LD; i++) begin
				sgl_q[i] <= sgl_q[i-1];
			end
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign last_out = lst_q[LAT-1];
	assign status = status_q;
	assign inv_d1 = inv_q[0];
	assign inv_d2 = inv_q[1];
	assign inv_d3 = inv_q[2];
	assign inv_o1 = inv_q[3];
	assign inv_o2 = inv_q[4];
	assign inv_o3 = inv_q[5];

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q == csi_pkg::ST_SING |->
		inv_d1 == 64'd0 && inv_d2 == 64'd0 && inv_d3 == 64'd0 &&
		inv_o1 == 64'd0 && inv_o2 == 64'd0 && inv_o3 == 64'd0)
		else $error("singular result with nonzero entries");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transfer not tracked");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(det_s11) && $stable(vld_q[0]))
		else $error("pipeline moved during stall");

	a_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q == csi_pkg::ST_OK |-> !$past(any_sat, 1) || !$past(en, 1))
		else $error("ok status despite saturation");

endmodule
`default_nettype wire

[rtl/csi_smul.sv]
// Pipelined signed multiplier built from limb partial products.
`default_nettype none
module csi_smul (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [csi_pkg::WX-1:0]  a,
	input  wire logic signed [csi_pkg::WX-1:0]  b,
	output logic signed [csi_pkg::WP-1:0]       p
);

	logic [csi_pkg::WX-1:0] ua, ub;
	logic [csi_pkg::WL-1:0] ma_s1, mb_s1;
	logic                   sg_s1, sg_s2, sg_s3;
	logic [2*csi_pkg::LW-1:0] pp_s2 [csi_pkg::LIMBS][csi_pkg::LIMBS];
	logic [csi_pkg::WQ-1:0] row_s3 [csi_pkg::LIMBS];
	logic [csi_pkg::WQ-1:0] row_d [csi_pkg::LIMBS];
	logic [csi_pkg::WQ-1:0] acc;

	assign ua = a[csi_pkg::WX-1] ? csi_pkg::WX'(-a) : csi_pkg::WX'(a);
	assign ub = b[csi_pkg::WX-1] ? csi_pkg::WX'(-b) : csi_pkg::WX'(b);

	always_comb begin
		for (int i = 0; i < csi_pkg::LIMBS; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < csi_pkg::LIMBS; j++) begin
				row_d[i] = row_d[i] + (csi_pkg::WQ'(pp_s2[i][j]) << (j * csi_pkg::LW));
			end
		end
		acc = '0;
		for (int i = 0; i < csi_pkg::LIMBS; i++) begin
			acc = acc + (row_s3[i] << (i * csi_pkg::LW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= (csi_pkg::WL)'(ua);
			mb_s1 <= (csi_pkg::WL)'(ub);
			sg_s1 <= a[csi_pkg::WX-1] ^ b[csi_pkg::WX-1];
			for (int i = 0; i < csi_pkg::LIMBS; i++) begin
				for (int j = 0; j < csi_pkg::LIMBS; j++) begin
					pp_s2[i][j] <= (2*csi_pkg::LW)'(ma_s1[i*csi_pkg::LW +: csi_pkg::LW]) *
						(2*csi_pkg::LW)'(mb_s1[j*csi_pkg::LW +: csi_pkg::LW]);
				end
			end
			sg_s2 <= sg_s1;
			row_s3 <= row_d;
			sg_s3 <= sg_s2;
			p <= sg_s3 ? -$signed(acc[csi_pkg::WP-1:0]) : $signed(acc[csi_pkg::WP-1:0]);
		end
	end

endmodule
`default_nettype wire

[rtl/csi_cmul.sv]
// Pipelined complex multiplier: four real products and a combining stage.
`default_nettype none
module csi_cmul (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire csi_pkg::cx_t a,
	input  wire csi_pkg::cx_t b,
	output csi_pkg::cp_t      p
);

	logic signed [csi_pkg::WP-1:0] rr, ii, ri, ir;

	csi_smul u_rr (.clk(clk), .en(en), .a(a.re), .b(b.re), .p(rr));
	csi_smul u_ii (.clk(clk), .en(en), .a(a.im), .b(b.im), .p(ii));
	csi_smul u_ri (.clk(clk), .en(en), .a(a.re), .b(b.im), .p(ri));
	csi_smul u_ir (.clk(clk), .en(en), .a(a.im), .b(b.re), .p(ir));

	always_ff @(posedge clk) begin
		if (en) begin
			p.re <= rr - ii;
			p.im <= ri + ir;
		end
	end

endmodule
`default_nettype wire

[rtl/csi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with saturation.
`default_nettype none
module csi_div (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [csi_pkg::WP-1:0] num,
	input  wire logic [csi_pkg::WP-1:0]        mag,
	output logic [csi_pkg::P-1:0]              q,
	output logic                               sat
);

	localparam logic [csi_pkg::P-1:0] MINP = {1'b1, {(csi_pkg::P-1){1'b0}}};
	localparam logic [csi_pkg::P-1:0] MAXP = {1'b0, {(csi_pkg::P-1){1'b1}}};

	logic [csi_pkg::WC-1:0] r_s   [csi_pkg::P+1];
	logic [csi_pkg::WP-1:0] m_s   [csi_pkg::P+1];
	logic [csi_pkg::P-1:0]  q_s   [csi_pkg::P+1];
	logic                   neg_s [csi_pkg::P+1];
	logic                   ovf_s [csi_pkg::P+1];
	logic [csi_pkg::WP-1:0] abs_n;
	logic [csi_pkg::WC-1:0] rin;
	logic [csi_pkg::P-1:0]  qf;
	logic                   big;

	assign abs_n = num[csi_pkg::WP-1] ? csi_pkg::WP'(-num) : csi_pkg::WP'(num);
	assign rin = csi_pkg::WC'(abs_n) << (2 * csi_pkg::F);
	assign qf = q_s[csi_pkg::P];
	assign big = ovf_s[csi_pkg::P] || (neg_s[csi_pkg::P] ? (qf > MINP) : qf[csi_pkg::P-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= rin;
			m_s[0] <= mag;
			q_s[0] <= '0;
			neg_s[0] <= num[csi_pkg::WP-1];
			ovf_s[0] <= rin >= (csi_pkg::WC'(mag) << csi_pkg::P);
			if (big) begin
				q <= neg_s[csi_pkg::P] ? MINP : MAXP;
				sat <= 1'b1;
			end else begin
				q <= neg_s[csi_pkg::P] ? -qf : qf;
				sat <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < csi_pkg::P; k++) begin : g_step
		logic [csi_pkg::WC-1:0] t;
		logic                   ge;
		assign t = csi_pkg::WC'(m_s[k]) << (csi_pkg::P - 1 - k);
		assign ge = r_s[k] >= t;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= ge ? r_s[k] - t : r_s[k];
				q_s[k+1] <= {q_s[k][csi_pkg::P-2:0], ge};
				m_s[k+1] <= m_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

endmodule
`default_nettype wire

[bench/csi_checker.sv]
// Checker: predicts the inverse of each accepted matrix and compares the output transfers.
module csi_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] alpha_d1,
	input  wire logic [63:0] alpha_d2,
	input  wire logic [63:0] alpha_d3,
	input  wire logic [63:0] alpha_o1,
	input  wire logic [63:0] alpha_o2,
	input  wire logic [63:0] alpha_o3,
	input  wire logic        last_in,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] inv_d1,
	input  wire logic [63:0] inv_d2,
	input  wire logic [63:0] inv_d3,
	input  wire logic [63:0] inv_o1,
	input  wire logic [63:0] inv_o2,
	input  wire logic [63:0] inv_o3,
	input  wire logic [1:0]  status,
	input  wire logic        last_out,
	output int               errors,
	output int               pending
);

	typedef logic signed [319:0] wd_t;
	typedef struct {
		wd_t re;
		wd_t im;
	} cw_t;
	typedef struct {
		logic [63:0] ent [6];
		logic [1:0]  st;
		logic        last;
	} inverse_t;

	inverse_t inv_q[$];

	function automatic cw_t unpack_cx(input logic [63:0] v);
		cw_t r;
		r.re = $signed(v[63:32]);
		r.im = $signed(v[31:0]);
		return r;
	endfunction

	function automatic cw_t cmul(input cw_t a, input cw_t b);
		cw_t r;
		r.re = a.re * b.re - a.im * b.im;
		r.im = a.re * b.im + a.im * b.re;
		return r;
	endfunction

	function automatic cw_t csub(input cw_t a, input cw_t b);
		cw_t r;
		r.re = a.re - b.re;
		r.im = a.im - b.im;
		return r;
	endfunction

	function automatic logic [31:0] clamp_part(input wd_t q, inout logic sat);
		wd_t hi, lo;
		hi = 64'sh7FFFFFFF;
		lo = -64'sh80000000;
		if (q > hi) begin
			sat = 1'b1;
			return 32'h7FFFFFFF;
		end
		if (q < lo) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return q[31:0];
	endfunction

	function automatic inverse_t invert(input logic [63:0] v [6], input logic last);
		inverse_t r;
		cw_t a1, a2, a3, b1, b2, b3, s1, s2, s3, t, det, n;
		cw_t num [6];
		wd_t mag, rn, in_;
		logic sat;
		a1 = unpack_cx(v[0]); a2 = unpack_cx(v[1]); a3 = unpack_cx(v[2]);
		b1 = unpack_cx(v[3]); b2 = unpack_cx(v[4]); b3 = unpack_cx(v[5]);
		s1 = cmul(b1, b1); s2 = cmul(b2, b2); s3 = cmul(b3, b3);
		t = cmul(cmul(b1, b2), b3);
		det = cmul(cmul(a1, a2), a3);
		det.re = det.re + 2 * t.re;
		det.im = det.im + 2 * t.im;
		det = csub(det, cmul(a1, s1));
		det = csub(det, cmul(a2, s2));
		det = csub(det, cmul(a3, s3));
		r.last = last;
		sat = 1'b0;
		if (det.re == 0 && det.im == 0) begin
			foreach (r.ent[k]) r.ent[k] = '0;
			r.st = csi_pkg::ST_SING;
			return r;
		end
		num[0] = csub(cmul(a2, a3), s1);
		num[1] = csub(cmul(a3, a1), s2);
		num[2] = csub(cmul(a1, a2), s3);
		num[3] = csub(cmul(b2, b3), cmul(a1, b1));
		num[4] = csub(cmul(b3, b1), cmul(a2, b2));
		num[5] = csub(cmul(b1, b2), cmul(a3, b3));
		mag = det.re * det.re + det.im * det.im;
		for (int k = 0; k < 6; k++) begin
			n = num[k];
			rn = (n.re * det.re + n.im * det.im) <<< 32;
			in_ = (n.im * det.re - n.re * det.im) <<< 32;
			r.ent[k][63:32] = clamp_part(rn / mag, sat);
			r.ent[k][31:0] = clamp_part(in_ / mag, sat);
		end
		r.st = sat ? csi_pkg::ST_SAT : csi_pkg::ST_OK;
		return r;
	endfunction

	initial errors = 0;
	assign pending = inv_q.size();

	always @(posedge clk) begin
		logic [63:0] mat [6];
		logic [63:0] got [6];
		string nm [6];
		inverse_t e;
		nm = '{"inv_d1", "inv_d2", "inv_d3", "inv_o1", "inv_o2", "inv_o3"};
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mat = '{alpha_d1, alpha_d2, alpha_d3, alpha_o1, alpha_o2, alpha_o3};
				inv_q.push_back(invert(mat, last_in));
			end
			if (out_valid && out_ready) begin
				if (inv_q.size() == 0) begin
					$error("output transfer with no matrix outstanding");
					errors++;
				end else begin
					e = inv_q.pop_front();
					got = '{inv_d1, inv_d2, inv_d3, inv_o1, inv_o2, inv_o3};
					for (int k = 0; k < 6; k++)
						if (got[k] !== e.ent[k]) begin
							$error("%s: expected %h, got %h", nm[k], e.ent[k], got[k]);
							errors++;
						end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						errors++;
					end
					if (last_out !== e.last) begin
						$error("last_out: expected %0d, got %0d", e.last, last_out);
						errors++;
					end
				end
			end
		end
	end
endmodule

[bench/tb_complex_symmetric_3x3_inverse.sv]
// Testbench top: matrix stimulus, output flow control and the final verdict.
module tb_complex_symmetric_3x3_inverse;
	localparam logic [63:0] ONE = 64'h00010000_00000000;
	localparam int N_RAND = 1280;
	localparam int LIMIT = 200000;

	logic clk, arst_n, in_valid, in_ready, last_in, out_valid, out_ready, last_out;
	logic [63:0] alpha_d1, alpha_d2, alpha_d3, alpha_o1, alpha_o2, alpha_o3;
	logic [63:0] inv_d1, inv_d2, inv_d3, inv_o1, inv_o2, inv_o3;
	logic [1:0] status;
	int errors, pending, cycles;
	bit no_idle, hold_req;

	complex_symmetric_3x3_inverse DUT (.*);
	csi_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send(input logic [63:0] d1, d2, d3, o1, o2, o3, input logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		alpha_d1 <= d1; alpha_d2 <= d2; alpha_d3 <= d3;
		alpha_o1 <= o1; alpha_o2 <= o2; alpha_o3 <= o3;
		last_in <= lst;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [31:0] small_part();
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	function automatic logic [63:0] small_cx();
		return {small_part(), small_part()};
	endfunction

	function automatic logic [63:0] full_cx();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] tiny_cx();
		return {32'($urandom_range(0, 6)) - 32'd3, 32'($urandom_range(0, 6)) - 32'd3};
	endfunction

	// output side flow control
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [63:0] m [6];
		logic [63:0] x;
		int mode;
		cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0; out_ready = 1'b0; last_in = 1'b0;
		alpha_d1 = '0; alpha_d2 = '0; alpha_d3 = '0;
		alpha_o1 = '0; alpha_o2 = '0; alpha_o3 = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: singular, identity, extremes, saturation, scaled diag
		send('0, '0, '0, '0, '0, '0, 1'b0);
		send(ONE, ONE, ONE, '0, '0, '0, 1'b1);
		send({32'h7FFFFFFF, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h7FFFFFFF},
			{32'h7FFFFFFF, 32'h7FFFFFFF}, '0, '0, '0, 1'b0);
		send({32'h80000000, 32'h80000000}, {32'h80000000, 32'h80000000},
			{32'h80000000, 32'h80000000}, {32'h80000000, 32'h80000000},
			{32'h80000000, 32'h80000000}, {32'h80000000, 32'h80000000}, 1'b0);
		send('1, '1, '1, '1, '1, '1, 1'b1);
		send(64'h1, 64'h1, 64'h1, '0, '0, '0, 1'b0);
		send(64'h1_00000000, 64'h1_00000000, 64'h1_00000000, '0, '0, '0, 1'b0);
		send({32'h7FFFFFFF, 32'h0}, {32'h80000000, 32'h0}, {32'h7FFFFFFF, 32'h0},
			{32'h7FFFFFFF, 32'h0}, {32'h7FFFFFFF, 32'h0}, {32'h80000000, 32'h0}, 1'b0);
		send(ONE, ONE, ONE, ONE, ONE, ONE, 1'b0);
		send('0, '0, '0, ONE, ONE, ONE, 1'b1);
		send(64'h00020000_00010000, 64'h00030000_FFFF0000, 64'h00010000_00000000,
			64'h00008000_00000000, 64'hFFFF8000_00004000, 64'h00000000_00010000, 1'b0);
		send({32'h0, 32'h00010000}, {32'h0, 32'h00010000}, {32'h0, 32'h00010000},
			'0, '0, '0, 1'b0);
		send(ONE, ONE, ONE, 64'h00000001_00000000, '0, '0, 1'b1);
		send(64'h7FFFFFFF_80000000, ONE, 64'h80000000_7FFFFFFF,
			64'h12345678_9ABCDEF0, 64'h0F0F0F0F_F0F0F0F0, 64'hAAAAAAAA_55555555, 1'b0);
		send(64'h55555555_AAAAAAAA, 64'hAAAAAAAA_55555555, 64'hFFFFFFFF_00000001,
			64'h00000001_FFFFFFFF, 64'h80000001_7FFFFFFE, 64'h00010001_00010001, 1'b1);

		for (int i = 0; i < N_RAND; i++) begin
			no_idle = (i >= 300 && i < 400);
			if (i == 600) hold_req = 1;
			if (i == 900) begin
				in_valid <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 6; k++) begin
				case (mode)
					0, 1, 2: m[k] = full_cx();
					7: m[k] = tiny_cx();
					8: m[k] = (k < 3) ? small_cx() : 64'h0;
					default: m[k] = small_cx();
				endcase
			end
			if (mode == 9) begin
				// rank one: every entry equal
				x = small_cx();
				foreach (m[k]) m[k] = x;
			end
			send(m[0], m[1], m[2], m[3], m[4], m[5], 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;
		no_idle = 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
